/* hdl/bdcc_pkg.sv */
`timescale 1ns / 1ps

package bdcc_pkg;

  // width of the press elapsed counter, saturating at all ones
  localparam int unsigned ElapsedBits = 17;

  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_DEBOUNCE_COUNT   = 8'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CLICK_LIMIT_MS   = 8'd1;
  localparam logic [CfgIdxBits-1:0] CFG_PRESSED_LEVEL    = 8'd2;
  localparam logic [CfgIdxBits-1:0] CFG_TICKS_PER_SECOND = 8'd3;

  localparam logic [7:0]  DEBOUNCE_COUNT_RST   = 8'd10;
  localparam logic [15:0] CLICK_LIMIT_MS_RST   = 16'd1000;
  localparam logic        PRESSED_LEVEL_RST    = 1'b0;
  localparam logic [9:0]  TICKS_PER_SECOND_RST = 10'd1000;
  // released level for the reset pressed level
  localparam logic        STABLE_LEVEL_RST     = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_CLICK = 2'd2,
    EV_LONG  = 2'd3
  } bdcc_event_e;

  typedef struct packed {
    logic [7:0]  debounce_count;
    logic [15:0] click_limit_ms;
    logic        pressed_level;
    logic [9:0]  ticks_per_second;
  } bdcc_cfg_t;

  typedef struct packed {
    logic                   stable_level;
    logic [7:0]             agree_count;
    logic                   press_tracked;
    logic [ElapsedBits-1:0] press_elapsed_ms;
    logic [9:0]             sub_second_ticks;
    logic [15:0]            held_second_count;
  } bdcc_state_t;

  typedef struct packed {
    bdcc_event_e event_res;
    logic [15:0] held_seconds;
    logic        is_pressed;
  } bdcc_res_t;

endpackage

/* hdl/bdcc_step.sv */
`timescale 1ns / 1ps

module bdcc_step (
  input  bdcc_pkg::bdcc_cfg_t   cfg_i,
  input  bdcc_pkg::bdcc_state_t state_i,
  input  logic                  raw_level_i,
  input  logic                  force_release_i,
  output bdcc_pkg::bdcc_state_t state_o,
  output bdcc_pkg::bdcc_res_t   res_o
);

  logic [7:0]                       agree_inc;
  logic [bdcc_pkg::ElapsedBits-1:0] elapsed_adv;
  logic [9:0]                       sub_inc;
  logic                             sec_roll;
  logic [9:0]                       sub_adv;
  logic [15:0]                      held_adv;
  logic                             tracked;
  logic                             pressed;
  bdcc_pkg::bdcc_state_t            st;
  bdcc_pkg::bdcc_event_e            ev;

  assign agree_inc = (state_i.agree_count == 8'hFF) ? state_i.agree_count
                                                     : state_i.agree_count + 8'd1;

  // press time advance, used on both the hold and the release tick
  assign elapsed_adv = (&state_i.press_elapsed_ms) ? state_i.press_elapsed_ms
                     : state_i.press_elapsed_ms + bdcc_pkg::ElapsedBits'(1);
  assign sub_inc  = state_i.sub_second_ticks + 10'd1;
  assign sec_roll = (sub_inc >= cfg_i.ticks_per_second);
  assign sub_adv  = sec_roll ? 10'd0 : sub_inc;
  assign held_adv = (sec_roll && state_i.held_second_count != 16'hFFFF)
                  ? state_i.held_second_count + 16'd1 : state_i.held_second_count;

  always_comb begin
    st = state_i;
    ev = bdcc_pkg::EV_NONE;

    if (raw_level_i != state_i.stable_level) begin
      if (agree_inc >= cfg_i.debounce_count) begin
        st.stable_level = raw_level_i;
        st.agree_count  = 8'd0;
      end else begin
        st.agree_count = agree_inc;
      end
    end else begin
      st.agree_count = 8'd0;
    end

    tracked = state_i.press_tracked & ~force_release_i;
    pressed = (st.stable_level == cfg_i.pressed_level);
    st.press_tracked = tracked;

    if (!pressed) begin
      if (tracked) begin
        if (elapsed_adv < bdcc_pkg::ElapsedBits'(cfg_i.click_limit_ms)) begin
          ev = bdcc_pkg::EV_CLICK;
        end
        st.press_tracked     = 1'b0;
        st.press_elapsed_ms  = '0;
        st.sub_second_ticks  = 10'd0;
        st.held_second_count = 16'd0;
      end
    end else if (!tracked) begin
      st.press_tracked     = 1'b1;
      st.press_elapsed_ms  = '0;
      st.sub_second_ticks  = 10'd0;
      st.held_second_count = 16'd0;
      ev = bdcc_pkg::EV_PRESS;
    end else begin
      st.press_elapsed_ms  = elapsed_adv;
      st.sub_second_ticks  = sub_adv;
      st.held_second_count = held_adv;
      ev = (elapsed_adv > bdcc_pkg::ElapsedBits'(cfg_i.click_limit_ms))
         ? bdcc_pkg::EV_LONG : bdcc_pkg::EV_PRESS;
    end
  end

  assign state_o            = st;
  assign res_o.event_res    = ev;
  assign res_o.held_seconds = st.press_tracked ? st.held_second_count : 16'd0;
  assign res_o.is_pressed   = pressed;

endmodule

/* hdl/button_debounce_click_classifier.sv */
`timescale 1ns / 1ps
// a sample in the input register reaches out_valid_o via the result register
// throughput: one sample per cycle when not stalled; input and result registers
// advance together whenever the result register is empty or being taken
// reset: asynchronous, active low; config, valid and state registers return to
// their defaults: debounced level to released, all press counters to zero
module button_debounce_click_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                raw_level_i,
  input  logic                                force_release_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          event_res_o,
  output logic [15:0]                         held_seconds_o,
  output logic                                is_pressed_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdcc_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [bdcc_pkg::CfgDataBits-1:0]    cfg_data_i
);

  bdcc_pkg::bdcc_cfg_t   cfg_q;
  bdcc_pkg::bdcc_state_t state_q, state_d;
  bdcc_pkg::bdcc_res_t   res_d, res_q;

  logic in_vld_q;
  logic raw_q;
  logic force_q;
  logic out_vld_q;
  logic advance;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count   <= bdcc_pkg::DEBOUNCE_COUNT_RST;
      cfg_q.click_limit_ms   <= bdcc_pkg::CLICK_LIMIT_MS_RST;
      cfg_q.pressed_level    <= bdcc_pkg::PRESSED_LEVEL_RST;
      cfg_q.ticks_per_second <= bdcc_pkg::TICKS_PER_SECOND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdcc_pkg::CFG_DEBOUNCE_COUNT:   cfg_q.debounce_count   <= cfg_data_i[7:0];
        bdcc_pkg::CFG_CLICK_LIMIT_MS:   cfg_q.click_limit_ms   <= cfg_data_i[15:0];
        bdcc_pkg::CFG_PRESSED_LEVEL:    cfg_q.pressed_level    <= cfg_data_i[0];
        bdcc_pkg::CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // result register free, so the held sample moves on
  assign advance    = ~out_vld_q | ~out_stall_i;
  assign in_take    = in_vld_q & advance;
  assign in_stall_o = in_vld_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      raw_q   <= raw_level_i;
      force_q <= force_release_i;
    end
  end

  bdcc_step u_step (
    .cfg_i           (cfg_q),
    .state_i         (state_q),
    .raw_level_i     (raw_q),
    .force_release_i (force_q),
    .state_o         (state_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stable_level      <= bdcc_pkg::STABLE_LEVEL_RST;
      state_q.agree_count       <= 8'd0;
      state_q.press_tracked     <= 1'b0;
      state_q.press_elapsed_ms  <= '0;
      state_q.sub_second_ticks  <= 10'd0;
      state_q.held_second_count <= 16'd0;
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = res_q.event_res;
  assign held_seconds_o = res_q.held_seconds;
  assign is_pressed_o   = res_q.is_pressed;

`ifndef SYNTHESIS
  // a click is only reported on the release tick
  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.event_res == bdcc_pkg::EV_CLICK |-> !res_q.is_pressed)
    else $error("click reported while pressed");

  a_long_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.event_res == bdcc_pkg::EV_LONG |-> res_q.is_pressed)
    else $error("long press reported while released");

  a_released_no_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.is_pressed |-> res_q.held_seconds == 16'd0)
    else $error("held seconds nonzero while released");

  // a sample held in the input register while the result is stalled stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(raw_q) && $stable(force_q))
    else $error("input register lost a stalled sample");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_take |=> $stable(state_q))
    else $error("state changed without a sample");
`endif

endmodule
